// ----- design/llsm_pkg.sv -----
// Shared types for the linked-list slot manager: command and status codes,
// the input and result word structs, and the sequencer state encoding.
// No dependencies.
`timescale 1ns / 1ps

package llsm_pkg;

  typedef enum logic [2:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_INS_BEFORE = 3'd2,
    CMD_INS_AFTER  = 3'd3,
    CMD_ERASE_SLOT = 3'd4,
    CMD_ERASE_POS  = 3'd5,
    CMD_READ_SLOT  = 3'd6,
    CMD_READ_POS   = 3'd7
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOT_USED = 2'd1,
    ST_BAD_POS  = 2'd2,
    ST_FULL     = 2'd3
  } status_e;

  typedef enum logic [13:0] {
    S_CLEAR   = 14'b00000000000001,
    S_IDLE    = 14'b00000000000010,
    S_LOOK    = 14'b00000000000100,
    S_CHECK   = 14'b00000000001000,
    S_WALK    = 14'b00000000010000,
    S_WSTEP   = 14'b00000000100000,
    S_TAKE    = 14'b00000001000000,
    S_TAKE2   = 14'b00000010000000,
    S_TAKE3   = 14'b00000100000000,
    S_TAKE4   = 14'b00001000000000,
    S_UNLINK  = 14'b00010000000000,
    S_UNLINK2 = 14'b00100000000000,
    S_UNLINK3 = 14'b01000000000000,
    S_DONE    = 14'b10000000000000
  } state_e;

  typedef struct packed {
    cmd_e        command;
    logic [3:0]  slot;
    logic [3:0]  position;
    logic [31:0] value;
  } llsm_in_t;

  typedef struct packed {
    status_e     status;
    logic [3:0]  result_slot;
    logic [31:0] result_value;
    logic [4:0]  element_count;
  } llsm_out_t;

endpackage

// ----- design/linked_list_slot_manager_unit.sv -----
// Top level of the linked-list slot manager: sequencer, link/data stores
// and the output register. Depends on llsm_pkg.
`timescale 1ns / 1ps

//  channel  direction  handshake                  payload
//  in       input      in_valid_i / in_ready_o    in_word_i   (llsm_pkg::llsm_in_t)
//  out      output     out_valid_o / out_ready_i  out_word_o  (llsm_pkg::llsm_out_t)
//
// One read port shared by the stores means each command steps through sequencer
// states before its result reaches the output register: a read or erase by position
// walks the list slot by slot from the head, and a refused command ends early.
// The sequencer then returns to S_IDLE, with in_ready_o high, before the next accept.
// After reset a clearing pass over every slot rebuilds the free chain first.
// A finished word waits in the output register while the next command runs,
// and that command stalls in its last state only while the previous word is unread.

module linked_list_slot_manager_unit #(
  parameter int SLOTS      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  llsm_pkg::llsm_in_t  in_word_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output llsm_pkg::llsm_out_t out_word_o
);
  import llsm_pkg::*;

  // SW indexes a slot; LW also holds the "none" link value, which is SLOTS.
  localparam int SW = $clog2(SLOTS);
  localparam int LW = $clog2(SLOTS + 1);
  localparam int DW = DATA_WIDTH;
  localparam logic [LW-1:0] NONE     = LW'(SLOTS);
  localparam logic [SW-1:0] LAST_IDX = SW'(SLOTS - 1);

  // Slot stores. Each has one write port; all share one registered read port.
  logic [LW-1:0] next_mem [SLOTS];
  logic [LW-1:0] prev_mem [SLOTS];
  logic          used_mem [SLOTS];
  logic [DW-1:0] data_mem [SLOTS];

  logic [SW-1:0] rd_addr;
  logic [LW-1:0] nxt_rd_q, prv_rd_q;
  logic          use_rd_q;
  logic [DW-1:0] dat_rd_q;

  logic          nxt_we, prv_we, use_we, dat_we, use_wd;
  logic [SW-1:0] nxt_wa, prv_wa, slot_wa;
  logic [LW-1:0] nxt_wd, prv_wd;
  logic [DW-1:0] dat_wd;

  // Control registers.
  state_e        state_q, state_d;
  logic [LW-1:0] head_q, head_d, tail_q, tail_d, free_q, free_d, count_q, count_d;
  logic [SW-1:0] clr_q, clr_d;
  logic          out_valid_q, out_valid_d;

  // Command and working registers.
  cmd_e          cmd_q, cmd_d;
  logic [3:0]    slot_q, slot_d, pos_q, pos_d;
  logic [DW-1:0] val_q, val_d;
  logic [LW-1:0] s_q, s_d, a_q, a_d, b_q, b_d;
  status_e       res_status_q, res_status_d;
  logic [LW-1:0] res_slot_q, res_slot_d;
  logic [DW-1:0] res_val_q, res_val_d;
  llsm_out_t     out_q, out_d;

  logic in_fire;
  logic slot_ok;

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  // The slot field is only four bits; a small store may not reach all of them.
  assign slot_ok = (32'(slot_q) < 32'(SLOTS));

  always_comb begin
    state_d      = state_q;
    head_d       = head_q;
    tail_d       = tail_q;
    free_d       = free_q;
    count_d      = count_q;
    clr_d        = clr_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    cmd_d        = cmd_q;
    slot_d       = slot_q;
    pos_d        = pos_q;
    val_d        = val_q;
    s_d          = s_q;
    a_d          = a_q;
    b_d          = b_q;
    res_status_d = res_status_q;
    res_slot_d   = res_slot_q;
    res_val_d    = res_val_q;
    out_d        = out_q;

    rd_addr = '0;
    nxt_we  = 1'b0;
    prv_we  = 1'b0;
    use_we  = 1'b0;
    dat_we  = 1'b0;
    nxt_wa  = '0;
    prv_wa  = '0;
    slot_wa = '0;
    nxt_wd  = '0;
    prv_wd  = '0;
    use_wd  = 1'b0;
    dat_wd  = val_q;

    case (state_q)
      S_CLEAR: begin
        // Rebuild the free chain 0 -> 1 -> ... -> SLOTS-1 and clear the flags.
        nxt_we  = 1'b1;
        prv_we  = 1'b1;
        use_we  = 1'b1;
        nxt_wa  = clr_q;
        prv_wa  = clr_q;
        slot_wa = clr_q;
        nxt_wd  = LW'(clr_q) + 1'b1;
        prv_wd  = (clr_q == '0) ? NONE : LW'(clr_q) - 1'b1;
        if (clr_q == LAST_IDX) begin
          state_d = S_IDLE;
        end else begin
          clr_d = clr_q + 1'b1;
        end
      end

      S_IDLE: begin
        if (in_fire) begin
          cmd_d        = in_word_i.command;
          slot_d       = in_word_i.slot;
          pos_d        = in_word_i.position;
          val_d        = DW'(in_word_i.value);
          res_status_d = ST_OK;
          res_slot_d   = '0;
          res_val_d    = '0;
          state_d      = S_LOOK;
        end
      end

      S_LOOK: begin
        case (cmd_q)
          CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
            if (count_q == NONE) begin
              res_status_d = ST_FULL;
              state_d      = S_DONE;
            end else begin
              a_d     = (cmd_q == CMD_PUSH_FRONT) ? NONE : tail_q;
              b_d     = (cmd_q == CMD_PUSH_FRONT) ? head_q : NONE;
              state_d = S_TAKE;
            end
          end
          CMD_ERASE_POS, CMD_READ_POS: begin
            if (32'(pos_q) >= 32'(count_q)) begin
              res_status_d = ST_BAD_POS;
              state_d      = S_DONE;
            end else begin
              s_d     = head_q;
              state_d = S_WALK;
            end
          end
          default: begin
            // Slot-addressed commands fetch the slot's links, flag and data.
            if (!slot_ok) begin
              res_status_d = ST_NOT_USED;
              state_d      = S_DONE;
            end else begin
              rd_addr = SW'(slot_q);
              state_d = S_CHECK;
            end
          end
        endcase
      end

      S_CHECK: begin
        if (!use_rd_q) begin
          res_status_d = ST_NOT_USED;
          state_d      = S_DONE;
        end else begin
          case (cmd_q)
            CMD_READ_SLOT: begin
              res_slot_d = LW'(slot_q);
              res_val_d  = dat_rd_q;
              state_d    = S_DONE;
            end
            CMD_ERASE_SLOT: begin
              s_d     = LW'(slot_q);
              a_d     = prv_rd_q;
              b_d     = nxt_rd_q;
              state_d = S_UNLINK;
            end
            CMD_INS_BEFORE, CMD_INS_AFTER: begin
              if (count_q == NONE) begin
                res_status_d = ST_FULL;
                state_d      = S_DONE;
              end else begin
                a_d     = (cmd_q == CMD_INS_BEFORE) ? prv_rd_q : LW'(slot_q);
                b_d     = (cmd_q == CMD_INS_BEFORE) ? LW'(slot_q) : nxt_rd_q;
                state_d = S_TAKE;
              end
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end

      S_WALK: begin
        // Fetch the current slot; the step state then either stops or moves on.
        if (s_q >= NONE) begin
          res_status_d = ST_BAD_POS;
          state_d      = S_DONE;
        end else begin
          rd_addr = s_q[SW-1:0];
          state_d = S_WSTEP;
        end
      end

      S_WSTEP: begin
        if (pos_q == '0) begin
          res_slot_d = s_q;
          if (cmd_q == CMD_READ_POS) begin
            res_val_d = dat_rd_q;
            state_d   = S_DONE;
          end else begin
            a_d     = prv_rd_q;
            b_d     = nxt_rd_q;
            state_d = S_UNLINK;
          end
        end else begin
          s_d     = nxt_rd_q;
          pos_d   = pos_q - 1'b1;
          state_d = S_WALK;
        end
      end

      S_TAKE: begin
        s_d = free_q;
        if (free_q >= NONE) begin
          res_slot_d = NONE;
          state_d    = S_DONE;
        end else begin
          rd_addr = free_q[SW-1:0];
          state_d = S_TAKE2;
        end
      end

      S_TAKE2: begin
        // Pop the free head: its successor becomes the new free head.
        free_d  = nxt_rd_q;
        prv_we  = (nxt_rd_q < NONE);
        prv_wa  = nxt_rd_q[SW-1:0];
        prv_wd  = NONE;
        nxt_we  = 1'b1;
        nxt_wa  = s_q[SW-1:0];
        nxt_wd  = b_q;
        dat_we  = 1'b1;
        use_we  = 1'b1;
        slot_wa = s_q[SW-1:0];
        use_wd  = 1'b1;
        state_d = S_TAKE3;
      end

      S_TAKE3: begin
        prv_we = 1'b1;
        prv_wa = s_q[SW-1:0];
        prv_wd = a_q;
        if (a_q < NONE) begin
          nxt_we = 1'b1;
          nxt_wa = a_q[SW-1:0];
          nxt_wd = s_q;
        end else begin
          head_d = s_q;
        end
        state_d = S_TAKE4;
      end

      S_TAKE4: begin
        if (b_q < NONE) begin
          prv_we = 1'b1;
          prv_wa = b_q[SW-1:0];
          prv_wd = s_q;
        end else begin
          tail_d = s_q;
        end
        count_d    = count_q + 1'b1;
        res_slot_d = s_q;
        state_d    = S_DONE;
      end

      S_UNLINK: begin
        // Bridge the neighbors around the slot being erased.
        if (a_q < NONE) begin
          nxt_we = 1'b1;
          nxt_wa = a_q[SW-1:0];
          nxt_wd = b_q;
        end else begin
          head_d = b_q;
        end
        if (b_q < NONE) begin
          prv_we = 1'b1;
          prv_wa = b_q[SW-1:0];
          prv_wd = a_q;
        end else begin
          tail_d = a_q;
        end
        state_d = S_UNLINK2;
      end

      S_UNLINK2: begin
        nxt_we  = 1'b1;
        nxt_wa  = s_q[SW-1:0];
        nxt_wd  = free_q;
        prv_we  = 1'b1;
        prv_wa  = s_q[SW-1:0];
        prv_wd  = NONE;
        use_we  = 1'b1;
        slot_wa = s_q[SW-1:0];
        use_wd  = 1'b0;
        state_d = S_UNLINK3;
      end

      S_UNLINK3: begin
        // The erased slot goes back on the head of the free chain.
        if (free_q < NONE) begin
          prv_we = 1'b1;
          prv_wa = free_q[SW-1:0];
          prv_wd = s_q;
        end
        free_d = s_q;
        if (count_q != '0) begin
          count_d = count_q - 1'b1;
        end
        res_slot_d = s_q;
        state_d    = S_DONE;
      end

      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_d.status        = res_status_q;
          out_d.result_slot   = 4'(res_slot_q);
          out_d.result_value  = 32'(res_val_q);
          out_d.element_count = 5'(count_q);
          out_valid_d         = 1'b1;
          state_d             = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      head_q      <= NONE;
      tail_q      <= NONE;
      free_q      <= '0;
      count_q     <= '0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      free_q      <= free_d;
      count_q     <= count_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Command, working and result payload.
  always_ff @(posedge clk_i) begin
    cmd_q        <= cmd_d;
    slot_q       <= slot_d;
    pos_q        <= pos_d;
    val_q        <= val_d;
    s_q          <= s_d;
    a_q          <= a_d;
    b_q          <= b_d;
    res_status_q <= res_status_d;
    res_slot_q   <= res_slot_d;
    res_val_q    <= res_val_d;
    out_q        <= out_d;
  end

  // Slot stores with registered read data.
  always_ff @(posedge clk_i) begin
    if (nxt_we) begin
      next_mem[nxt_wa] <= nxt_wd;
    end
    if (prv_we) begin
      prev_mem[prv_wa] <= prv_wd;
    end
    if (use_we) begin
      used_mem[slot_wa] <= use_wd;
    end
    if (dat_we) begin
      data_mem[slot_wa] <= dat_wd;
    end
    nxt_rd_q <= next_mem[rd_addr];
    prv_rd_q <= prev_mem[rd_addr];
    use_rd_q <= used_mem[rd_addr];
    dat_rd_q <= data_mem[rd_addr];
  end

endmodule

// ----- tb/llsm_result_checker.sv -----
// Result checker for the linked-list slot manager: keeps its own copy of the
// slot store, predicts each result word and compares it with the block's output.
// Depends on llsm_pkg.
`timescale 1ns / 1ps

module llsm_result_checker
  import llsm_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_ready_i,
  input  llsm_in_t         in_word_i,
  input  logic             out_valid_i,
  input  logic             out_ready_i,
  input  llsm_out_t        out_word_i,
  output int               error_count_o,
  output int               pending_o,
  output logic [15:0]      in_use_o,
  output logic [4:0]       elements_o
);

  localparam int SLOTS = 16;
  // Link value that points at no slot.
  localparam logic [4:0] NO_SLOT = 5'd16;

  logic [4:0]       link_next [SLOTS];
  logic [4:0]       link_prev [SLOTS];
  logic [31:0]      slot_value [SLOTS];
  logic [SLOTS-1:0] slot_taken;
  logic [4:0]       list_head;
  logic [4:0]       list_tail;
  logic [4:0]       free_head;
  logic [4:0]       list_size;

  llsm_out_t awaited_results [$];
  llsm_out_t want;

  assign in_use_o   = slot_taken;
  assign elements_o = list_size;

  // Takes the slot at the head of the free chain and links it between a and b.
  function automatic logic [4:0] take_slot(logic [4:0] a, logic [4:0] b, logic [31:0] v);
    logic [4:0] s;
    s = free_head;
    if (s[4]) return NO_SLOT;
    free_head = link_next[s[3:0]];
    if (!free_head[4]) link_prev[free_head[3:0]] = NO_SLOT;
    link_prev[s[3:0]] = a;
    link_next[s[3:0]] = b;
    if (!a[4]) link_next[a[3:0]] = s;
    else list_head = s;
    if (!b[4]) link_prev[b[3:0]] = s;
    else list_tail = s;
    slot_value[s[3:0]] = v;
    slot_taken[s[3:0]] = 1'b1;
    list_size++;
    return s;
  endfunction

  // Unlinks slot s and returns it to the head of the free chain.
  function automatic void release_slot(logic [3:0] s);
    logic [4:0] a;
    logic [4:0] b;
    a = link_prev[s];
    b = link_next[s];
    if (!a[4]) link_next[a[3:0]] = b;
    else list_head = b;
    if (!b[4]) link_prev[b[3:0]] = a;
    else list_tail = a;
    link_next[s] = free_head;
    link_prev[s] = NO_SLOT;
    if (!free_head[4]) link_prev[free_head[3:0]] = {1'b0, s};
    free_head = {1'b0, s};
    slot_taken[s] = 1'b0;
    if (list_size > 0) list_size--;
  endfunction

  // Applies one command to the local store and returns the result word it gives.
  function automatic llsm_out_t apply_list_command(llsm_in_t w);
    llsm_out_t  r;
    logic [4:0] s;
    int         k;
    r = '0;
    r.status = ST_OK;
    case (w.command)
      CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
        if (list_size >= SLOTS) begin
          r.status = ST_FULL;
        end else begin
          if (w.command == CMD_PUSH_FRONT) s = take_slot(NO_SLOT, list_head, w.value);
          else s = take_slot(list_tail, NO_SLOT, w.value);
          r.result_slot = s[3:0];
        end
      end
      CMD_INS_BEFORE, CMD_INS_AFTER: begin
        // The slot check wins over the full check.
        if (!slot_taken[w.slot]) begin
          r.status = ST_NOT_USED;
        end else if (list_size >= SLOTS) begin
          r.status = ST_FULL;
        end else begin
          if (w.command == CMD_INS_BEFORE) begin
            s = take_slot(link_prev[w.slot], {1'b0, w.slot}, w.value);
          end else begin
            s = take_slot({1'b0, w.slot}, link_next[w.slot], w.value);
          end
          r.result_slot = s[3:0];
        end
      end
      CMD_ERASE_SLOT: begin
        if (!slot_taken[w.slot]) begin
          r.status = ST_NOT_USED;
        end else begin
          release_slot(w.slot);
          r.result_slot = w.slot;
        end
      end
      CMD_ERASE_POS, CMD_READ_POS: begin
        if (w.position >= list_size) begin
          r.status = ST_BAD_POS;
        end else begin
          s = list_head;
          k = w.position;
          while (k > 0 && !s[4]) begin
            s = link_next[s[3:0]];
            k--;
          end
          if (s[4]) begin
            r.status = ST_BAD_POS;
          end else begin
            r.result_slot = s[3:0];
            if (w.command == CMD_ERASE_POS) release_slot(s[3:0]);
            else r.result_value = slot_value[s[3:0]];
          end
        end
      end
      default: begin
        if (!slot_taken[w.slot]) begin
          r.status = ST_NOT_USED;
        end else begin
          r.result_slot  = w.slot;
          r.result_value = slot_value[w.slot];
        end
      end
    endcase
    r.element_count = list_size;
    return r;
  endfunction

  function automatic void check_field(string field, logic [31:0] expected,
                                      logic [31:0] actual);
    if (expected !== actual) begin
      error_count_o++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, expected, actual);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SLOTS; i++) begin
        link_next[i]  = 5'(i + 1);
        link_prev[i]  = (i == 0) ? NO_SLOT : 5'(i - 1);
        slot_value[i] = '0;
      end
      slot_taken    = '0;
      list_head     = NO_SLOT;
      list_tail     = NO_SLOT;
      free_head     = '0;
      list_size     = '0;
      error_count_o = 0;
      pending_o     = 0;
      awaited_results.delete();
    end else begin
      // The outgoing word is matched first, so a result and a command in the
      // same cycle never pair up with each other.
      if (out_valid_i && out_ready_i) begin
        if (awaited_results.size() == 0) begin
          error_count_o++;
          $display("%0t: result word with nothing outstanding, expected none, got %h",
                   $time, out_word_i);
        end else begin
          want = awaited_results.pop_front();
          check_field("status", want.status, out_word_i.status);
          check_field("result_slot", want.result_slot, out_word_i.result_slot);
          check_field("result_value", want.result_value, out_word_i.result_value);
          check_field("element_count", want.element_count, out_word_i.element_count);
        end
      end
      if (in_valid_i && in_ready_i) awaited_results.push_back(apply_list_command(in_word_i));
      pending_o = awaited_results.size();
    end
  end

endmodule

// ----- tb/linked_list_slot_manager_unit_tb.sv -----
// Testbench top for the linked-list slot manager: clock, reset, command
// stimulus and result-side back-pressure. Depends on llsm_pkg, the block and
// llsm_result_checker.
`timescale 1ns / 1ps

module linked_list_slot_manager_unit_tb;
  import llsm_pkg::*;

  // Longest run of cycles in which no word moves on either channel. The
  // slowest legitimate stretch is the long receiver hold-off, so this leaves
  // plenty of margin.
  localparam int STALL_LIMIT   = 2000;
  localparam int RANDOM_ITEMS  = 525;
  // The sender stops after this many random commands and waits until every
  // expected result has arrived.
  localparam int DRAIN_AT      = 300;
  // Once this many results have been taken, the receiver holds off for a long
  // stretch so the output register and then the command input back up.
  localparam int HOLD_AT       = 150;
  localparam int HOLD_CYCLES   = 300;
  // Cycles allowed after the last expected result for any stray word to show.
  localparam int TAIL_CYCLES   = 60;

  logic      clk_i = 1'b0;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_ready_o;
  llsm_in_t  in_word_i;
  logic      out_valid_o;
  logic      out_ready_i;
  llsm_out_t out_word_o;

  int          error_count;
  int          pending;
  logic [15:0] in_use;
  logic [4:0]  elements;
  int          results_taken = 0;

  always #4 clk_i = ~clk_i;

  linked_list_slot_manager_unit #(
    .SLOTS      (16),
    .DATA_WIDTH (32)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o)
  );

  // The checker predicts every result and also exposes the list occupancy, so
  // the stimulus can aim most commands at slots and positions that exist.
  llsm_result_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_i    (in_ready_o),
    .in_word_i     (in_word_i),
    .out_valid_i   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_word_i    (out_word_o),
    .error_count_o (error_count),
    .pending_o     (pending),
    .in_use_o      (in_use),
    .elements_o    (elements)
  );

  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) results_taken <= results_taken + 1;
  end

  // Holds the command word on the input until the block takes it. The caller
  // has already moved to a falling edge, so valid stays high across a burst
  // without ever being lowered and raised in the same step.
  task automatic send_word(input llsm_in_t w);
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic send_fixed(input cmd_e c, input logic [3:0] s, input logic [3:0] p,
                            input logic [31:0] v);
    @(negedge clk_i);
    send_word('{command: c, slot: s, position: p, value: v});
  endtask

  // Builds a random command. While the list is growing, pushes and inserts
  // dominate; while it shrinks, erases do. Most slot and position fields
  // point at live elements so the deeper link updates are exercised, and
  // about one in ten is left as noise to provoke the error statuses.
  function automatic llsm_in_t random_word(bit growing);
    llsm_in_t   w;
    int         roll;
    logic [3:0] s;
    roll = $urandom_range(0, 99);
    if (growing) begin
      if (roll < 20)      w.command = CMD_PUSH_FRONT;
      else if (roll < 40) w.command = CMD_PUSH_BACK;
      else if (roll < 52) w.command = CMD_INS_BEFORE;
      else if (roll < 64) w.command = CMD_INS_AFTER;
      else if (roll < 70) w.command = CMD_ERASE_SLOT;
      else if (roll < 76) w.command = CMD_ERASE_POS;
      else if (roll < 88) w.command = CMD_READ_SLOT;
      else                w.command = CMD_READ_POS;
    end else begin
      if (roll < 6)       w.command = CMD_PUSH_FRONT;
      else if (roll < 12) w.command = CMD_PUSH_BACK;
      else if (roll < 16) w.command = CMD_INS_BEFORE;
      else if (roll < 20) w.command = CMD_INS_AFTER;
      else if (roll < 45) w.command = CMD_ERASE_SLOT;
      else if (roll < 70) w.command = CMD_ERASE_POS;
      else if (roll < 85) w.command = CMD_READ_SLOT;
      else                w.command = CMD_READ_POS;
    end
    w.slot     = 4'($urandom_range(0, 15));
    w.position = 4'($urandom_range(0, 15));
    case ($urandom_range(0, 19))
      0:       w.value = '0;
      1:       w.value = '1;
      default: w.value = $urandom();
    endcase
    if (elements != 0 && $urandom_range(0, 9) != 0) begin
      s = w.slot;
      while (!in_use[s]) s++;
      w.slot     = s;
      w.position = 4'($urandom_range(0, elements - 1));
    end
    return w;
  endfunction

  // Receiver: changes its ready pattern after each segment of random length, from
  // always ready through random and mostly stalled to alternating, and performs the
  // single long hold-off once enough results have gone by.
  initial begin
    int mode;
    int seg;
    bit held;
    held = 1'b0;
    out_ready_i <= 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      seg  = $urandom_range(8, 64);
      repeat (seg) begin
        @(negedge clk_i);
        if (!held && results_taken >= HOLD_AT) begin
          held = 1'b1;
          out_ready_i <= 1'b0;
          repeat (HOLD_CYCLES) @(negedge clk_i);
        end
        case (mode)
          0:       out_ready_i <= 1'b1;
          1:       out_ready_i <= 1'($urandom_range(0, 1));
          2:       out_ready_i <= ($urandom_range(0, 3) == 0);
          default: out_ready_i <= ~out_ready_i;
        endcase
      end
    end
  end

  // Watchdog: a run where no word moves for too long has hung.
  initial begin
    int idle;
    idle = 0;
    while (idle < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle = 0;
      else idle++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    int sent;
    int burst;
    bit growing;
    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    in_word_i  <= '0;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part. Free slots are handed out in order after reset, so the
    // slot numbers below are known: 0 and 1 first, then 2 becomes the head,
    // 3 the tail, and 4 and 5 land in the middle.
    // The not-used and bad-position statuses on an empty list first.
    send_fixed(CMD_READ_SLOT, 4'd15, 4'd0, 32'h0);
    send_fixed(CMD_READ_POS, 4'd0, 4'd0, 32'h0);
    send_fixed(CMD_ERASE_POS, 4'd0, 4'd15, 32'h0);
    send_fixed(CMD_INS_AFTER, 4'd0, 4'd0, 32'h1234_5678);
    send_fixed(CMD_PUSH_BACK, 4'd0, 4'd0, 32'h0000_0000);
    send_fixed(CMD_PUSH_FRONT, 4'd0, 4'd0, 32'hFFFF_FFFF);
    // Insert before the head and after the tail behave like pushes.
    send_fixed(CMD_INS_BEFORE, 4'd1, 4'd0, 32'hA5A5_5A5A);
    send_fixed(CMD_INS_AFTER, 4'd0, 4'd0, 32'h5A5A_A5A5);
    send_fixed(CMD_INS_BEFORE, 4'd0, 4'd0, 32'h8000_0000);
    send_fixed(CMD_INS_AFTER, 4'd1, 4'd0, 32'h0000_0001);
    send_fixed(CMD_READ_POS, 4'd0, 4'd0, 32'h0);
    send_fixed(CMD_READ_SLOT, 4'd4, 4'd0, 32'h0);
    // Position equal to the element count is just out of range.
    send_fixed(CMD_READ_POS, 4'd0, 4'd6, 32'h0);
    // Fill the store completely.
    for (int i = 0; i < 10; i++) begin
      send_fixed((i % 2 == 0) ? CMD_PUSH_FRONT : CMD_PUSH_BACK, 4'd0, 4'd0, $urandom());
    end
    // A full store refuses pushes and inserts.
    send_fixed(CMD_PUSH_BACK, 4'd0, 4'd0, 32'hDEAD_BEEF);
    send_fixed(CMD_INS_AFTER, 4'd7, 4'd0, 32'hDEAD_BEEF);
    send_fixed(CMD_READ_POS, 4'd0, 4'd15, 32'h0);
    send_fixed(CMD_READ_SLOT, 4'd15, 4'd0, 32'h0);
    send_fixed(CMD_ERASE_POS, 4'd0, 4'd15, 32'h0);
    send_fixed(CMD_ERASE_SLOT, 4'd2, 4'd0, 32'h0);
    send_fixed(CMD_ERASE_SLOT, 4'd2, 4'd0, 32'h0);

    // Random part: bursts of back-to-back words separated by random gaps,
    // with the list swinging between growth and shrinkage so its size sweeps
    // the whole range from empty to full.
    sent    = 0;
    growing = 1'b1;
    while (sent < RANDOM_ITEMS) begin
      burst = $urandom_range(1, 24);
      while (burst > 0 && sent < RANDOM_ITEMS) begin
        @(negedge clk_i);
        if (elements == 5'd16 && $urandom_range(0, 3) == 0) growing = 1'b0;
        else if (elements == 5'd0 && $urandom_range(0, 3) == 0) growing = 1'b1;
        else if ($urandom_range(0, 49) == 0) growing = !growing;
        send_word(random_word(growing));
        sent++;
        burst--;
        if (sent == DRAIN_AT) begin
          @(negedge clk_i);
          in_valid_i <= 1'b0;
          while (pending != 0) @(negedge clk_i);
        end
      end
      if ($urandom_range(0, 2) != 0) begin
        repeat ($urandom_range(1, 10)) begin
          @(negedge clk_i);
          in_valid_i <= 1'b0;
        end
      end
    end

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (TAIL_CYCLES) @(negedge clk_i);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- files.f -----
design/llsm_pkg.sv
design/linked_list_slot_manager_unit.sv
tb/llsm_result_checker.sv
tb/linked_list_slot_manager_unit_tb.sv
